// ----- hdl/pccal_pkg.sv -----
// Shared constants and types for the per-channel polynomial calibration block.
// Depends on nothing; the datapath modules and the top level import it.
package pccal_pkg;

    // Data path widths fixed by the Q16.16 format.
    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int TERMS_W = 4;
    localparam int DIVD_W  = 49;
    localparam int STEP_W  = 6;
    localparam int DIV_STEPS = 49;

    // Command codes.
    localparam logic [2:0] CMD_WRITE = 3'd0;
    localparam logic [2:0] CMD_CLEAR = 3'd1;
    localparam logic [2:0] CMD_POLY  = 3'd2;
    localparam logic [2:0] CMD_POS   = 3'd3;
    localparam logic [2:0] CMD_THR   = 3'd4;
    localparam logic [2:0] CMD_READ  = 3'd5;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_TERMS   = 2'd2;
    localparam logic [1:0] ST_SAT     = 2'd3;

    typedef logic signed [DATA_W-1:0] q16_t;

endpackage

// ----- hdl/pccal_mul.sv -----
// Shared signed 32x32 multiplier with a registered full-width product.
// Depends on pccal_pkg for the data width.
module pccal_mul (
    input  logic                clk,
    input  pccal_pkg::q16_t     a,
    input  pccal_pkg::q16_t     b,
    output logic signed [2*pccal_pkg::DATA_W-1:0] product
);
    import pccal_pkg::*;

    logic signed [2*DATA_W-1:0] product_reg;

    // One multiply per cycle, product held for the next stage.
    always_ff @(posedge clk)
    begin
        product_reg <= a * b;
    end

    assign product = product_reg;

endmodule

// ----- hdl/pccal_div.sv -----
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on pccal_pkg for widths and the step count.
module pccal_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [pccal_pkg::DIVD_W-1:0]      dividend,
    input  logic [pccal_pkg::DATA_W-1:0]      divisor,
    output logic                              done,
    output logic [pccal_pkg::DIVD_W-1:0]      quotient
);
    import pccal_pkg::*;

    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0] dvd_reg, dvd_next;
    logic [DATA_W-1:0] dsr_reg, dsr_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              fits;

    // One trial subtraction of the shifted remainder.
    always_comb
    begin
        shifted = {rem_reg, dvd_reg[DIVD_W-1]};
        diff    = shifted - {1'b0, dsr_reg};
        fits    = (shifted >= {1'b0, dsr_reg});
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            cnt_next = STEP_W'(DIV_STEPS);
            rem_next = '0;
            dvd_next = dividend;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            dvd_next  = {dvd_reg[DIVD_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == STEP_W'(1));
        end
    end

    // Step counter and done strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ----- hdl/per_channel_polynomial_calibration.sv -----
// Per-channel polynomial calibration: sequencer, coefficient and term stores.
// Depends on pccal_pkg, pccal_mul and pccal_div.
//
// A command beat is taken when start is high and busy is low; its result is
// shown for one cycle with done high, and cannot be held off by the receiver.
// Write, clear, unknown commands and missing channels finish in S_LOOK; read,
// position with a term count other than two and a polynomial of zero terms
// finish in S_TERMS; threshold and position with a zero slope finish in
// S_PC1. A polynomial of one term finishes in S_PLOAD, and each further term
// adds one S_MUL multiply state and one S_ADD scale-add state, set by the single shared multiplier.
// Position waits in S_DIV on the divider, which produces one quotient bit per
// cycle over 49 steps.
// Coefficient and term stores hold no reset value; present marks reset to 0.
module per_channel_polynomial_calibration #(
    parameter int CHANNELS  = 256,
    parameter int MAX_TERMS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            command,
    input  logic [7:0]            channel,
    input  logic [2:0]            term_index,
    input  logic [3:0]            term_count,
    input  pccal_pkg::q16_t       coefficient,
    input  pccal_pkg::q16_t       raw_value,
    output logic                  done,
    output pccal_pkg::q16_t       value,
    output logic                  above_threshold,
    output logic [1:0]            status
);
    import pccal_pkg::*;

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TERM_W = $clog2(MAX_TERMS);
    localparam int ADDR_W = CH_W + TERM_W;
    localparam int DEPTH  = CHANNELS * (2 ** TERM_W);

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOOK  = 4'd1;
    localparam logic [3:0] S_TERMS = 4'd2;
    localparam logic [3:0] S_PLOAD = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_ADD   = 4'd5;
    localparam logic [3:0] S_PC1   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;

    // Saturate a wide signed value to 32 bits; the top bit flags saturation.
    function automatic logic [DATA_W:0] sat32(input logic signed [DIVD_W:0] v);
        logic [DATA_W:0] r;
        if (v > (DIVD_W+1)'(signed'(32'h7fffffff)))
            r = {1'b1, 32'h7fffffff};
        else if (v < (DIVD_W+1)'(signed'(32'h80000000)))
            r = {1'b1, 32'h80000000};
        else
            r = {1'b0, v[DATA_W-1:0]};
        return r;
    endfunction

    logic [3:0]          state_reg, state_next;
    logic [2:0]          cmd_reg;
    logic [CH_W-1:0]     chi_reg;
    logic                inr_reg;
    logic [2:0]          ti_reg;
    logic [3:0]          tc_reg;
    q16_t                cf_reg;
    q16_t                raw_reg;
    q16_t                acc_reg, acc_next;
    q16_t                c0_reg, c0_next;
    logic [TERMS_W-1:0]  idx_reg, idx_next;
    logic                sat_reg, sat_next;
    logic                done_reg, done_next;
    q16_t                value_reg, value_next;
    logic                above_reg, above_next;
    logic [1:0]          status_reg, status_next;
    logic [CHANNELS-1:0] present_reg;

    // Stores and their registered read data.
    q16_t                coef_mem [DEPTH];
    logic [TERMS_W-1:0]  term_mem [CHANNELS];
    q16_t                coef_rd_reg;
    logic [TERMS_W-1:0]  term_rd_reg;
    logic [TERM_W-1:0]   rd_idx;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic                clr_en;
    logic [TERMS_W-1:0]  tc_sat;

    // Shared arithmetic.
    logic signed [2*DATA_W-1:0] product;
    logic                       div_start;
    logic [DIVD_W-1:0]          div_dividend;
    logic [DATA_W-1:0]          div_divisor;
    logic                       div_done;
    logic [DIVD_W-1:0]          div_quot;

    logic                       present;
    logic [DATA_W:0]            s_mul, s_add, s_thr, s_div;
    logic signed [DATA_W:0]     diff;
    logic signed [DATA_W+2:0]   th;
    logic signed [DIVD_W:0]     q_signed;
    logic                       neg_res;

    pccal_mul u_mul (
        .clk     (clk),
        .a       (acc_reg),
        .b       (raw_reg),
        .product (product)
    );

    pccal_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign present = inr_reg && present_reg[chi_reg];
    assign tc_sat  = ({1'b0, term_count} > 5'(MAX_TERMS)) ? TERMS_W'(MAX_TERMS) : term_count;

    // Datapath arithmetic shared by the sequencer arms.
    // The divider works on magnitudes; the slope is held in acc_reg while it runs.
    always_comb
    begin
        s_mul = sat32((DIVD_W+1)'(product >>> FRAC_W));
        s_add = sat32((DIVD_W+1)'(signed'(s_mul[DATA_W-1:0]))
                      + (DIVD_W+1)'(coef_rd_reg));
        th    = (tc_reg == TERMS_W'(2))
              ? (DATA_W+3)'(c0_reg) + (DATA_W+3)'(coef_rd_reg)
                + ((DATA_W+3)'(coef_rd_reg) <<< 1)
              : (DATA_W+3)'(c0_reg);
        s_thr = sat32((DIVD_W+1)'(th));
        diff  = (DATA_W+1)'(raw_reg) - (DATA_W+1)'(c0_reg);
        div_dividend = DIVD_W'(diff[DATA_W] ? -diff : diff) << FRAC_W;
        div_divisor  = coef_rd_reg[DATA_W-1] ? DATA_W'(-coef_rd_reg) : DATA_W'(coef_rd_reg);
        neg_res  = diff[DATA_W] ^ acc_reg[DATA_W-1];
        q_signed = neg_res ? -(DIVD_W+1)'({1'b0, div_quot})
                           : (DIVD_W+1)'({1'b0, div_quot});
        s_div = sat32(q_signed);
    end

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        c0_next     = c0_reg;
        idx_next    = idx_reg;
        sat_next    = sat_reg;
        done_next   = 1'b0;
        value_next  = value_reg;
        above_next  = 1'b0;
        status_next = status_reg;
        rd_idx      = '0;
        wr_en       = 1'b0;
        clr_en      = 1'b0;
        div_start   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_LOOK;
            end
            S_LOOK:
            begin
                rd_idx      = (cmd_reg == CMD_READ) ? TERM_W'(ti_reg) : '0;
                value_next  = '0;
                status_next = ST_OK;
                state_next  = S_TERMS;
                sat_next    = 1'b0;
                if (cmd_reg == CMD_WRITE)
                begin
                    wr_en       = inr_reg;
                    status_next = !inr_reg ? ST_MISSING
                                : ({2'b00, ti_reg} >= 5'(MAX_TERMS)) ? ST_TERMS : ST_OK;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (cmd_reg == CMD_CLEAR || cmd_reg > CMD_READ)
                begin
                    clr_en     = (cmd_reg == CMD_CLEAR);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!present)
                begin
                    value_next  = (cmd_reg == CMD_POLY || cmd_reg == CMD_POS) ? raw_reg : '0;
                    status_next = ST_MISSING;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_TERMS:
            begin
                c0_next = coef_rd_reg;
                priority if (cmd_reg == CMD_READ)
                begin
                    if ({1'b0, ti_reg} >= term_rd_reg)
                        status_next = ST_TERMS;
                    else
                        value_next = coef_rd_reg;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (cmd_reg == CMD_POLY)
                begin
                    idx_next = term_rd_reg - 1'b1;
                    rd_idx   = TERM_W'(term_rd_reg - 1'b1);
                    if (term_rd_reg == '0)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                        state_next = S_PLOAD;
                end
                else if (cmd_reg == CMD_POS && term_rd_reg != TERMS_W'(2))
                begin
                    value_next  = raw_reg;
                    status_next = ST_TERMS;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    rd_idx     = TERM_W'(1);
                    state_next = S_PC1;
                end
            end
            S_PLOAD:
            begin
                acc_next = coef_rd_reg;
                if (idx_reg == '0)
                begin
                    value_next = coef_rd_reg;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                rd_idx     = TERM_W'(idx_reg - 1'b1);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                acc_next = s_add[DATA_W-1:0];
                sat_next = sat_reg | s_mul[DATA_W] | s_add[DATA_W];
                idx_next = idx_reg - 1'b1;
                if (idx_reg == TERMS_W'(1))
                begin
                    value_next  = s_add[DATA_W-1:0];
                    status_next = (sat_reg | s_mul[DATA_W] | s_add[DATA_W]) ? ST_SAT : ST_OK;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                    state_next = S_MUL;
            end
            S_PC1:
            begin
                if (cmd_reg == CMD_THR)
                begin
                    above_next  = ((DATA_W+3)'(raw_reg) > th);
                    value_next  = s_thr[DATA_W-1:0];
                    status_next = s_thr[DATA_W] ? ST_SAT : ST_OK;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (coef_rd_reg == '0)
                begin
                    value_next  = raw_reg;
                    status_next = ST_SAT;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    c0_next    = c0_reg;
                    acc_next   = coef_rd_reg;
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    value_next  = s_div[DATA_W-1:0];
                    status_next = s_div[DATA_W] ? ST_SAT : ST_OK;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_addr = {chi_reg, rd_idx};

    // Control state and present marks.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            above_reg   <= 1'b0;
            present_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            above_reg <= above_next;
            if (clr_en)
                present_reg <= '0;
            else if (wr_en)
                present_reg[chi_reg] <= 1'b1;
        end
    end

    // Command capture and working registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg <= command;
            chi_reg <= CH_W'(channel);
            inr_reg <= (17'(channel) < 17'(CHANNELS));
            ti_reg  <= term_index;
            tc_reg  <= tc_sat;
            cf_reg  <= coefficient;
            raw_reg <= raw_value;
        end
        else if (state_reg == S_TERMS)
            tc_reg <= term_rd_reg;
        acc_reg    <= acc_next;
        c0_reg     <= c0_next;
        idx_reg    <= idx_next;
        sat_reg    <= sat_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    // Coefficient and term stores.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            term_mem[chi_reg] <= tc_reg;
            if ({2'b00, ti_reg} < 5'(MAX_TERMS))
                coef_mem[{chi_reg, TERM_W'(ti_reg)}] <= cf_reg;
        end
        term_rd_reg <= term_mem[chi_reg];
        coef_rd_reg <= coef_mem[rd_addr];
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign value           = value_reg;
    assign above_threshold = above_reg;
    assign status          = status_reg;

    // A result is only shown once the sequencer is back at rest.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == S_IDLE))
        else $error("result strobe while sequencer busy");

    // An accepted beat always makes the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not start the sequencer");

    // The threshold flag never appears outside a result.
    a_above_done: assert property (@(posedge clk) disable iff (!rst_n)
        above_threshold |-> done)
        else $error("threshold flag without result strobe");

endmodule

// ----- sim/per_channel_polynomial_calibration_tb.sv -----
// Self-checking testbench for the per-channel polynomial calibration block.
// Depends on pccal_pkg and per_channel_polynomial_calibration; predicts every
// result beat from its own copy of the coefficient table and checks it.
`timescale 1ns / 1ps

module per_channel_polynomial_calibration_tb;
    import pccal_pkg::*;

    localparam int NCH = 256;
    localparam int NTERMS = 8;
    localparam int RANDOM_ITEMS = 1150;
    localparam longint CYCLE_LIMIT = 1000000;
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] channel;
        logic [2:0] term_index;
        logic [3:0] term_count;
        q16_t       coefficient;
        q16_t       raw_value;
    } cal_cmd_t;

    typedef struct packed {
        q16_t       value;
        logic       above;
        logic [1:0] status;
    } cal_result_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [2:0] command;
    logic [7:0] channel;
    logic [2:0] term_index;
    logic [3:0] term_count;
    q16_t coefficient;
    q16_t raw_value;
    logic done;
    q16_t value;
    logic above_threshold;
    logic [1:0] status;

    per_channel_polynomial_calibration i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .channel(channel),
        .term_index(term_index),
        .term_count(term_count),
        .coefficient(coefficient),
        .raw_value(raw_value),
        .done(done),
        .value(value),
        .above_threshold(above_threshold),
        .status(status)
    );

    // Shadow calibration table.
    q16_t       shadow_coeff [NCH][NTERMS];
    logic       shadow_written [NCH][NTERMS];
    logic [3:0] shadow_terms [NCH];
    logic       shadow_present [NCH];

    cal_cmd_t    pending_cmds[$];
    cal_result_t expected_results[$];
    int          mismatch_count;
    int          result_count;
    int          accepted_count;
    longint      cycle_count;
    bit          stimulus_done;

    // Q16.16 product rounded toward minus infinity (arithmetic shift does it).
    function automatic longint q16_product(q16_t a, q16_t b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> 16;
    endfunction

    function automatic q16_t clamp32(longint v, ref bit sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1;
            return 32'sh80000000;
        end
        return q16_t'(v);
    endfunction

    // Predict one result beat and update the shadow table.
    function automatic cal_result_t calibrate(cal_cmd_t c);
        cal_result_t r;
        bit present;
        bit sat;
        int terms;
        int ch;
        q16_t acc;
        longint num;
        longint th;
        ch = c.channel;
        present = shadow_present[ch];
        terms = present ? shadow_terms[ch] : 0;
        sat = 0;
        r = '0;
        case (c.command)
            CMD_WRITE:
            begin
                if (c.term_index < NTERMS)
                begin
                    shadow_coeff[ch][c.term_index] = c.coefficient;
                    shadow_written[ch][c.term_index] = 1;
                end
                else
                    r.status = ST_TERMS;
                shadow_terms[ch] = (c.term_count > NTERMS) ? 4'(NTERMS) : c.term_count;
                shadow_present[ch] = 1;
            end
            CMD_CLEAR:
                for (int i = 0; i < NCH; i++)
                    shadow_present[i] = 0;
            CMD_POLY:
            begin
                if (!present)
                begin
                    r.value = c.raw_value;
                    r.status = ST_MISSING;
                end
                else
                begin
                    if (terms > 0)
                    begin
                        acc = shadow_coeff[ch][terms-1];
                        for (int i = terms - 2; i >= 0; i--)
                        begin
                            acc = clamp32(q16_product(acc, c.raw_value), sat);
                            acc = clamp32(longint'(acc) + longint'(shadow_coeff[ch][i]), sat);
                        end
                        r.value = acc;
                    end
                    r.status = sat ? ST_SAT : ST_OK;
                end
            end
            CMD_POS:
            begin
                if (!present)
                begin
                    r.value = c.raw_value;
                    r.status = ST_MISSING;
                end
                else if (terms != 2)
                begin
                    r.value = c.raw_value;
                    r.status = ST_TERMS;
                end
                else if (shadow_coeff[ch][1] == 0)
                begin
                    r.value = c.raw_value;
                    r.status = ST_SAT;
                end
                else
                begin
                    num = (longint'(c.raw_value) - longint'(shadow_coeff[ch][0])) * 65536;
                    r.value = clamp32(num / longint'(shadow_coeff[ch][1]), sat);
                    r.status = sat ? ST_SAT : ST_OK;
                end
            end
            CMD_THR:
            begin
                if (!present)
                    r.status = ST_MISSING;
                else
                begin
                    th = longint'(shadow_coeff[ch][0]);
                    if (terms == 2)
                        th = th + 3 * longint'(shadow_coeff[ch][1]);
                    r.above = longint'(c.raw_value) > th;
                    r.value = clamp32(th, sat);
                    r.status = sat ? ST_SAT : ST_OK;
                end
            end
            CMD_READ:
            begin
                if (!present)
                    r.status = ST_MISSING;
                else if (c.term_index >= terms)
                    r.status = ST_TERMS;
                else
                    r.value = shadow_coeff[ch][c.term_index];
            end
            default:
                ;
        endcase
        return r;
    endfunction

    // Generation-time view of the table, used to avoid reading unwritten terms.
    bit         gen_present [NCH];
    logic [3:0] gen_terms [NCH];
    bit         gen_written [NCH][NTERMS];

    function automatic q16_t pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return q16_t'($urandom_range(0, 20) * 65536) - 32'sd655360;
            3: return q16_t'($urandom) >>> $urandom_range(0, 31);
            default: return q16_t'($urandom);
        endcase
    endfunction

    // True when the command would never read a coefficient that was not written.
    function automatic bit gen_safe(cal_cmd_t c);
        int t;
        if (!gen_present[c.channel])
            return 1;
        t = gen_terms[c.channel];
        case (c.command)
            CMD_POLY:
                for (int i = 0; i < t; i++)
                    if (!gen_written[c.channel][i])
                        return 0;
            CMD_POS:
                if (t == 2)
                    return gen_written[c.channel][0] && gen_written[c.channel][1];
            CMD_THR:
                return gen_written[c.channel][0] && (t != 2 || gen_written[c.channel][1]);
            CMD_READ:
                if (c.term_index < t)
                    return gen_written[c.channel][c.term_index];
            default:
                ;
        endcase
        return 1;
    endfunction

    task automatic queue_cmd(cal_cmd_t c);
        int cnt;
        if (!gen_safe(c))
            return;
        pending_cmds = {pending_cmds, c};
        if (c.command == CMD_WRITE)
        begin
            cnt = c.term_count;
            if (c.term_index < NTERMS)
                gen_written[c.channel][c.term_index] = 1;
            gen_terms[c.channel] = (cnt > NTERMS) ? 4'(NTERMS) : c.term_count;
            gen_present[c.channel] = 1;
        end
        else if (c.command == CMD_CLEAR)
            for (int i = 0; i < NCH; i++)
                gen_present[i] = 0;
    endtask

    function automatic cal_cmd_t make_cmd(logic [2:0] op, logic [7:0] ch, logic [2:0] ti,
                                          logic [3:0] tc, q16_t cf, q16_t raw);
        cal_cmd_t c;
        c.command = op;
        c.channel = ch;
        c.term_index = ti;
        c.term_count = tc;
        c.coefficient = cf;
        c.raw_value = raw;
        return c;
    endfunction

    // Writes a full channel with random coefficients.
    task automatic load_channel(logic [7:0] ch, int n);
        for (int i = 0; i < (n == 0 ? 1 : n); i++)
            queue_cmd(make_cmd(CMD_WRITE, ch, 3'(i), 4'(n), pick_value(), q16_t'($urandom)));
    endtask

    // Clock and reset.
    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
    end

    // Stimulus: directed cases, then well-formed random traffic.
    initial
    begin
        int n;
        logic [7:0] ch;
        logic [2:0] op;
        // Missing channel for every command but write, including the spare codes.
        for (int k = 0; k < 8; k++)
            if (k != CMD_WRITE)
                queue_cmd(make_cmd(3'(k), 8'd255, 3'd7, 4'd15, 32'sh80000000, 32'sh7fffffff));
        // Linear channel with edge values.
        queue_cmd(make_cmd(CMD_WRITE, 8'd0, 3'd0, 4'd2, 32'sh7fffffff, 0));
        queue_cmd(make_cmd(CMD_WRITE, 8'd0, 3'd1, 4'd2, 32'sh7fffffff, 0));
        queue_cmd(make_cmd(CMD_THR, 8'd0, 3'd0, 4'd0, 0, 32'sh7fffffff));
        queue_cmd(make_cmd(CMD_POS, 8'd0, 3'd0, 4'd0, 0, 32'sh80000000));
        queue_cmd(make_cmd(CMD_POLY, 8'd0, 3'd0, 4'd0, 0, 32'sh7fffffff));
        queue_cmd(make_cmd(CMD_READ, 8'd0, 3'd1, 4'd0, 0, 0));
        queue_cmd(make_cmd(CMD_READ, 8'd0, 3'd2, 4'd0, 0, 0));
        // Zero slope, then a write with a large term count.
        queue_cmd(make_cmd(CMD_WRITE, 8'd0, 3'd1, 4'd2, 0, 0));
        queue_cmd(make_cmd(CMD_POS, 8'd0, 3'd0, 4'd0, 0, 32'sh00010000));
        queue_cmd(make_cmd(CMD_WRITE, 8'd1, 3'd0, 4'd15, 32'sh00020000, 0));
        load_channel(8'd1, 8);
        queue_cmd(make_cmd(CMD_POLY, 8'd1, 3'd0, 4'd0, 0, 32'sh80000000));
        queue_cmd(make_cmd(CMD_POS, 8'd1, 3'd0, 4'd0, 0, 32'sh00010000));
        // Zero terms.
        queue_cmd(make_cmd(CMD_WRITE, 8'd2, 3'd0, 4'd0, 32'sh12345678, 0));
        queue_cmd(make_cmd(CMD_POLY, 8'd2, 3'd0, 4'd0, 0, 32'sh00030000));
        queue_cmd(make_cmd(CMD_THR, 8'd2, 3'd0, 4'd0, 0, 32'sh12345679));
        queue_cmd(make_cmd(CMD_CLEAR, 8'd0, 3'd0, 4'd0, 0, 0));
        queue_cmd(make_cmd(CMD_READ, 8'd1, 3'd0, 4'd0, 0, 0));

        // Random part: loads, writes, clears and mostly evaluations, mostly on a small set of channels.
        while (pending_cmds.size() < RANDOM_ITEMS + 40)
        begin
            ch = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
            case ($urandom_range(0, 19))
                0, 1, 2:
                begin
                    n = $urandom_range(0, 9) < 7 ? $urandom_range(1, 3) : $urandom_range(0, 8);
                    load_channel(ch, n);
                end
                3:
                    queue_cmd(make_cmd(CMD_CLEAR, 8'($urandom), 3'($urandom), 4'($urandom),
                                       q16_t'($urandom), q16_t'($urandom)));
                4, 5:
                    queue_cmd(make_cmd(CMD_WRITE, ch, 3'($urandom), 4'($urandom),
                                       pick_value(), q16_t'($urandom)));
                default:
                begin
                    op = 3'($urandom_range(2, 7));
                    if (op == CMD_SPARE7 && $urandom_range(0, 3) != 0)
                        op = CMD_POS;
                    if (op == CMD_SPARE6 && $urandom_range(0, 3) != 0)
                        op = CMD_POLY;
                    queue_cmd(make_cmd(op, ch, 3'($urandom), 4'($urandom),
                                       q16_t'($urandom), pick_value()));
                end
            endcase
        end
        stimulus_done = 1;
    end

    // Driver: random gaps, then one command beat per accepting edge.
    int gap;
    always @(posedge clk or negedge rst_n)
    begin
        cal_cmd_t c;
        if (!rst_n)
        begin
            start <= 0;
            command <= '0;
            channel <= '0;
            term_index <= '0;
            term_count <= '0;
            coefficient <= '0;
            raw_value <= '0;
            gap <= 0;
        end
        else if (start && !busy)
        begin
            start <= 0;
            gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
                 : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 0);
        end
        else if (!start)
        begin
            if (gap > 0)
                gap <= gap - 1;
            else if (pending_cmds.size() > 0)
            begin
                c = pending_cmds.pop_front();
                command <= c.command;
                channel <= c.channel;
                term_index <= c.term_index;
                term_count <= c.term_count;
                coefficient <= c.coefficient;
                raw_value <= c.raw_value;
                start <= 1;
            end
        end
    end

    // Prediction at the accepting edge.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            expected_results = {expected_results,
                                calibrate({command, channel, term_index, term_count,
                                           coefficient, raw_value})};
            accepted_count++;
        end
    end

    // Monitor: compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin
        cal_result_t e;
        if (rst_n && done)
        begin
            result_count++;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result beat value=%h status=%0d",
                             value, status);
            end
            else
            begin
                e = expected_results.pop_front();
                if (value !== e.value || above_threshold !== e.above || status !== e.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $write("ERROR: beat %0d expected value=%h above=%b status=%0d, ",
                               result_count, e.value, e.above, e.status);
                        $display("got value=%h above=%b status=%0d",
                                 value, above_threshold, status);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ERROR: timeout after %0d cycles", cycle_count);
            $display("FAIL per_channel_polynomial_calibration");
            $finish;
        end
    end

    // End of run.
    initial
    begin
        mismatch_count = 0;
        result_count = 0;
        accepted_count = 0;
        cycle_count = 0;
        wait (stimulus_done);
        wait (pending_cmds.size() == 0 && !start);
        wait (expected_results.size() == 0);
        repeat (80) @(posedge clk);
        $display("Run covered %0d command beats and %0d result beats, %0d mismatches.",
                 accepted_count, result_count, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASS per_channel_polynomial_calibration");
        else
            $display("FAIL per_channel_polynomial_calibration");
        $finish;
    end

endmodule

// ----- per_channel_polynomial_calibration.f -----
hdl/pccal_pkg.sv
hdl/pccal_mul.sv
hdl/pccal_div.sv
hdl/per_channel_polynomial_calibration.sv
sim/per_channel_polynomial_calibration_tb.sv
